[rtl/spq_pkg.sv]
// Shared types and codes for the stable priority queue.
package spq_pkg;

  localparam int unsigned OCC_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2
  } spq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic pop;
    logic clr;
  } spq_cmd_t;

endpackage

[rtl/spq_cell.sv]
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell #(
  parameter int unsigned SEV_W = 8,
  parameter int unsigned ID_W  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::spq_cmd_t  cmd,
  input  logic [SEV_W-1:0]   new_sev,
  input  logic [ID_W-1:0]    new_id,
  input  logic               prev_valid,
  input  logic               prev_keep,
  input  logic [SEV_W-1:0]   prev_sev,
  input  logic [ID_W-1:0]    prev_id,
  input  logic               next_valid,
  input  logic [SEV_W-1:0]   next_sev,
  input  logic [ID_W-1:0]    next_id,
  output logic               valid,
  output logic               keep,
  output logic [SEV_W-1:0]   sev,
  output logic [ID_W-1:0]    id
);

  logic             valid_r, valid_nxt;
  logic [SEV_W-1:0] sev_r, sev_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;

  // An entry of equal or higher severity stays ahead of the new one.
  assign keep  = valid_r && (sev_r >= new_sev);
  assign valid = valid_r;
  assign sev   = sev_r;
  assign id    = id_r;

  always_comb begin
    valid_nxt = valid_r;
    sev_nxt   = sev_r;
    id_nxt    = id_r;
    if (cmd.clr) begin
      valid_nxt = 1'b0;
    end else if (cmd.ins) begin
      valid_nxt = valid_r | prev_valid;
      if (!keep) begin
        if (prev_keep) begin
          sev_nxt = new_sev;
          id_nxt  = new_id;
        end else begin
          sev_nxt = prev_sev;
          id_nxt  = prev_id;
        end
      end
    end else if (cmd.pop) begin
      valid_nxt = next_valid;
      sev_nxt   = next_sev;
      id_nxt    = next_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sev_r <= sev_nxt;
    id_r  <= id_nxt;
  end

endmodule

[rtl/stable_priority_queue_core.sv]
// Top level of the stable priority queue built as a chain of sorted cells.
// Busy stays low, so a command may be started in every cycle, and its
// result appears with out_valid high for exactly one cycle, the cycle
// after the command was taken. The receiver cannot stall the block, so it
// must take each result in that cycle. All cells compare their entry with
// the incoming severity at once and shift by one place toward or away from
// the head. Entries of equal severity leave in arrival order. No clearing
// pass is needed after reset.
module stable_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH   = 64,
  parameter int unsigned SEVERITY_BITS = 8,
  parameter int unsigned ID_BITS       = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_opcode,
  input  logic [SEVERITY_BITS-1:0]  in_severity,
  input  logic [ID_BITS-1:0]        in_entry_id,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [ID_BITS-1:0]        out_id,
  output logic [SEVERITY_BITS-1:0]  out_severity,
  output logic [spq_pkg::OCC_W-1:0] out_occupancy
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [QUEUE_DEPTH-1:0]   c_valid, c_keep;
  logic [SEVERITY_BITS-1:0] c_sev [QUEUE_DEPTH];
  logic [ID_BITS-1:0]       c_id  [QUEUE_DEPTH];

  spq_pkg::spq_cmd_t    cmd;
  spq_pkg::spq_status_t status_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 full, empty, take;
  logic                 out_valid_r;
  logic [1:0]           status_r;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [SEVERITY_BITS-1:0] sev_r, sev_nxt;
  logic [CNT_W+spq_pkg::OCC_W-1:0] occ_ext;

  assign busy  = 1'b0;
  assign take  = start && !busy;
  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);

  always_comb begin
    cmd        = '0;
    status_nxt = spq_pkg::ST_OK;
    cnt_nxt    = cnt_r;
    id_nxt     = '0;
    sev_nxt    = '0;
    if (take) begin
      unique case (in_opcode)
        spq_pkg::OP_INSERT: begin
          if (full) begin
            status_nxt = spq_pkg::ST_FULL;
          end else begin
            cmd.ins = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        spq_pkg::OP_POP: begin
          if (empty) begin
            status_nxt = spq_pkg::ST_EMPTY;
          end else begin
            cmd.pop = 1'b1;
            cnt_nxt = cnt_r - CNT_W'(1);
            id_nxt  = c_id[0];
            sev_nxt = c_sev[0];
          end
        end
        spq_pkg::OP_CLEAR: begin
          cmd.clr = 1'b1;
          cnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic                     p_valid, p_keep, n_valid;
      logic [SEVERITY_BITS-1:0] p_sev, n_sev;
      logic [ID_BITS-1:0]       p_id, n_id;

      if (g == 0) begin : g_head
        // The head acts as if a kept entry stood in front of it.
        assign p_valid = 1'b1;
        assign p_keep  = 1'b1;
        assign p_sev   = '0;
        assign p_id    = '0;
      end else begin : g_body
        assign p_valid = c_valid[g-1];
        assign p_keep  = c_keep[g-1];
        assign p_sev   = c_sev[g-1];
        assign p_id    = c_id[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign n_valid = 1'b0;
        assign n_sev   = '0;
        assign n_id    = '0;
      end else begin : g_inner
        assign n_valid = c_valid[g+1];
        assign n_sev   = c_sev[g+1];
        assign n_id    = c_id[g+1];
      end

      spq_cell #(
        .SEV_W (SEVERITY_BITS),
        .ID_W  (ID_BITS)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .new_sev    (in_severity),
        .new_id     (in_entry_id),
        .prev_valid (p_valid),
        .prev_keep  (p_keep),
        .prev_sev   (p_sev),
        .prev_id    (p_id),
        .next_valid (n_valid),
        .next_sev   (n_sev),
        .next_id    (n_id),
        .valid      (c_valid[g]),
        .keep       (c_keep[g]),
        .sev        (c_sev[g]),
        .id         (c_id[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    id_r     <= id_nxt;
    sev_r    <= sev_nxt;
  end

  // The occupancy field wraps when the count is wider than the port.
  assign occ_ext       = {{spq_pkg::OCC_W{1'b0}}, cnt_r};
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_id        = id_r;
  assign out_severity  = sev_r;
  assign out_occupancy = occ_ext[spq_pkg::OCC_W-1:0];

endmodule
